[hw/rtl/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// Fenced page bump allocator package
// Shared widths, codes and the page entry layout of the allocator core.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int MAX_PAGES   = 16;
   localparam int PAGE_IDX_W  = $clog2(MAX_PAGES);
   localparam int PAGE_CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int OFFSET_BITS = 25;
   localparam int ALIGN_W     = 5;
   localparam int FENCE_W     = 64;

   // Alignment arithmetic spans the largest alignment (2^31) plus one carry bit.
   localparam int SPAN_W = 32;
   localparam int END_W  = SPAN_W + 1;

   localparam logic [OFFSET_BITS-1:0] PAGE_BYTES_RESET = OFFSET_BITS'(65536);

   localparam int REQ_FIELDS_W = OFFSET_BITS + ALIGN_W + FENCE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = PAGE_IDX_W + OFFSET_BITS + PAGE_CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RECLAIM = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEW_PAGE  = 2'd1,
      STATUS_POOL_FULL = 2'd2,
      STATUS_TOO_LARGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [FENCE_W-1:0]     fence;
      logic [OFFSET_BITS-1:0] fill;
   } page_entry_type;

   localparam int PAGE_ENTRY_W = $bits(page_entry_type);

endpackage

[hw/rtl/fpba_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fenced_page_bump_allocator_core.sv]
// ----------------------------------------------------------------------------
// Fenced page bump allocator core
// Bump allocation over an ordered list of pages with fence-based recycling.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Contents
//   req_*       in         allocate or reclaim transaction
//   rsp_*       out        one result transaction per request
//   csr_*       in         page size register write
//
// After reset a sweep initializes the memories; no request is taken meanwhile.
// An allocate passes ST_A_SLOT and ST_A_CALC, loading its result in ST_A_CALC.
// A reclaim steps ST_R_ISSUE, ST_R_SLOT and ST_R_TEST per page examined, then
// ST_COPY rewrites the order list after a rotation and ST_R_DONE loads the result.
// A stalled result holds back the next result; the next request is still
// accepted meanwhile.
//
module fenced_page_bump_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fpba_pkg::OFFSET_BITS-1:0]    csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // request_bytes, align_log2, fence_value (from bit 0 up), zero padded
   input  logic [fpba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // page_index, byte_offset, pages_freed (from bit 0 up), zero padded
   output logic [fpba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status
   output logic [1:0]                          rsp_tuser
);

   import fpba_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_A_SLOT  = 9'b000000100,
      ST_A_CALC  = 9'b000001000,
      ST_R_ISSUE = 9'b000010000,
      ST_R_SLOT  = 9'b000100000,
      ST_R_TEST  = 9'b001000000,
      ST_COPY    = 9'b010000000,
      ST_R_DONE  = 9'b100000000
   } state_type;

   state_type                state_ff, state_in;
   logic [PAGE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PAGE_CNT_W-1:0]    k_ff, k_in;
   logic [PAGE_CNT_W-1:0]    piu_ff, piu_in;
   logic                     bank_ff, bank_in;
   logic [PAGE_IDX_W-1:0]    last_ff, last_in;
   logic [PAGE_IDX_W-1:0]    slot_ff, slot_in;
   logic [OFFSET_BITS-1:0]   page_bytes_ff, page_bytes_in;
   logic [OFFSET_BITS-1:0]   size_ff, size_in;
   logic [ALIGN_W-1:0]       align_ff, align_in;
   logic [FENCE_W-1:0]       fence_ff, fence_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [PAGE_IDX_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [OFFSET_BITS-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [PAGE_CNT_W-1:0]    rsp_freed_ff, rsp_freed_in;

   // Memory ports
   logic                     page_we;
   logic [PAGE_IDX_W-1:0]    page_waddr, page_raddr;
   page_entry_type           page_wdata;
   logic [PAGE_ENTRY_W-1:0]  page_rdata;
   logic                     ord0_we, ord1_we;
   logic [PAGE_IDX_W-1:0]    ord_waddr, ord_raddr, ord_wdata;
   logic [PAGE_IDX_W-1:0]    ord0_rdata, ord1_rdata, order_rdata;

   // Datapath
   page_entry_type           entry_rd;
   logic [SPAN_W-1:0]        fill_ext, align_mask, aligned;
   logic [END_W-1:0]         next_end;
   logic                     fits, too_large, pool_full, walk_stop, out_free, accept;
   logic [FENCE_W-1:0]       fence_max;
   logic [PAGE_CNT_W-1:0]    copy_sum, copy_wrap;
   logic [PAGE_IDX_W-1:0]    copy_raddr;

   fpba_ram #(.WIDTH(PAGE_ENTRY_W), .DEPTH(MAX_PAGES)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_waddr),
      .wr_data (page_wdata),
      .rd_addr (page_raddr),
      .rd_data (page_rdata)
   );

   // The order list lives in two banks; a rotation copies one into the other.
   fpba_ram #(.WIDTH(PAGE_IDX_W), .DEPTH(MAX_PAGES)) u_order_ram0 (
      .clock   (clock),
      .wr_en   (ord0_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord0_rdata)
   );

   fpba_ram #(.WIDTH(PAGE_IDX_W), .DEPTH(MAX_PAGES)) u_order_ram1 (
      .clock   (clock),
      .wr_en   (ord1_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord1_rdata)
   );

   assign order_rdata = bank_ff ? ord1_rdata : ord0_rdata;
   assign entry_rd    = page_entry_type'(page_rdata);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Bump arithmetic on the tail page.
   assign fill_ext   = SPAN_W'(entry_rd.fill);
   assign align_mask = (SPAN_W'(1) << align_ff) - SPAN_W'(1);
   assign aligned    = (fill_ext + align_mask) & ~align_mask;
   assign next_end   = END_W'(aligned) + END_W'(size_ff);
   assign fits       = next_end <= END_W'(page_bytes_ff);
   assign too_large  = size_ff > page_bytes_ff;
   assign pool_full  = piu_ff == PAGE_CNT_W'(MAX_PAGES);
   assign fence_max  = (fence_ff > entry_rd.fence) ? fence_ff : entry_rd.fence;

   // A page stops the walk when it is still in flight or holds nothing.
   assign walk_stop = (entry_rd.fence > fence_ff) || (entry_rd.fill == '0);

   // Source position for the rotation: (i + k) mod pages_in_use inside the list.
   assign copy_sum   = cnt_ff + k_ff;
   assign copy_wrap  = (copy_sum >= piu_ff) ? (copy_sum - piu_ff) : copy_sum;
   assign copy_raddr = (cnt_ff < piu_ff) ? copy_wrap[PAGE_IDX_W-1:0]
                                         : cnt_ff[PAGE_IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      piu_in        = piu_ff;
      bank_in       = bank_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      fence_in      = fence_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_freed_in  = rsp_freed_ff;
      page_bytes_in = csr_we ? csr_wdata : page_bytes_ff;

      page_we    = 1'b0;
      page_waddr = '0;
      page_wdata = '0;
      page_raddr = '0;
      ord0_we    = 1'b0;
      ord1_we    = 1'b0;
      ord_waddr  = '0;
      ord_wdata  = '0;
      ord_raddr  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            page_we    = 1'b1;
            page_waddr = cnt_ff[PAGE_IDX_W-1:0];
            ord0_we    = 1'b1;
            ord_waddr  = cnt_ff[PAGE_IDX_W-1:0];
            ord_wdata  = cnt_ff[PAGE_IDX_W-1:0];
            if (cnt_ff == PAGE_CNT_W'(MAX_PAGES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + PAGE_CNT_W'(1);
            end
         end
         ST_IDLE: begin
            ord_raddr = PAGE_IDX_W'(piu_ff - PAGE_CNT_W'(1));
            if (accept) begin
               size_in  = req_tdata[OFFSET_BITS-1:0];
               align_in = req_tdata[OFFSET_BITS +: ALIGN_W];
               fence_in = req_tdata[OFFSET_BITS + ALIGN_W +: FENCE_W];
               k_in     = '0;
               if (op_type'(req_tuser[0]) == OP_ALLOC) begin
                  state_in = ST_A_SLOT;
               end else begin
                  state_in = ST_R_ISSUE;
               end
            end
         end
         ST_A_SLOT: begin
            ord_raddr  = piu_ff[PAGE_IDX_W-1:0];
            page_raddr = order_rdata;
            last_in    = order_rdata;
            state_in   = ST_A_CALC;
         end
         ST_A_CALC: begin
            // Addresses are held so the read data stays put while the output stalls.
            ord_raddr  = piu_ff[PAGE_IDX_W-1:0];
            page_raddr = last_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_freed_in  = '0;
               rsp_page_in   = '0;
               rsp_offset_in = '0;
               priority if (fits) begin
                  rsp_status_in    = STATUS_OK;
                  rsp_page_in      = last_ff;
                  rsp_offset_in    = aligned[OFFSET_BITS-1:0];
                  page_we          = 1'b1;
                  page_waddr       = last_ff;
                  page_wdata.fill  = next_end[OFFSET_BITS-1:0];
                  page_wdata.fence = fence_max;
               end else if (too_large) begin
                  rsp_status_in = STATUS_TOO_LARGE;
               end else if (pool_full) begin
                  rsp_status_in = STATUS_POOL_FULL;
               end else begin
                  // The fresh page is empty, so the request lands at offset zero.
                  rsp_status_in    = STATUS_NEW_PAGE;
                  rsp_page_in      = order_rdata;
                  page_we          = 1'b1;
                  page_waddr       = order_rdata;
                  page_wdata.fill  = size_ff;
                  page_wdata.fence = fence_ff;
                  piu_in           = piu_ff + PAGE_CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_R_ISSUE: begin
            ord_raddr = k_ff[PAGE_IDX_W-1:0];
            if (k_ff == piu_ff) begin
               state_in = ST_R_DONE;
            end else begin
               state_in = ST_R_SLOT;
            end
         end
         ST_R_SLOT: begin
            ord_raddr  = k_ff[PAGE_IDX_W-1:0];
            page_raddr = order_rdata;
            slot_in    = order_rdata;
            state_in   = ST_R_TEST;
         end
         ST_R_TEST: begin
            page_raddr = slot_ff;
            if (walk_stop) begin
               cnt_in = '0;
               if (k_ff != '0) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_R_DONE;
               end
            end else begin
               page_we    = 1'b1;
               page_waddr = slot_ff;
               k_in       = k_ff + PAGE_CNT_W'(1);
               state_in   = ST_R_ISSUE;
            end
         end
         ST_COPY: begin
            // Read slot copy_raddr of the live bank; write slot cnt-1 of the other.
            ord_raddr = copy_raddr;
            ord_waddr = PAGE_IDX_W'(cnt_ff - PAGE_CNT_W'(1));
            ord_wdata = order_rdata;
            if (cnt_ff != '0) begin
               ord0_we = bank_ff;
               ord1_we = !bank_ff;
            end
            if (cnt_ff == PAGE_CNT_W'(MAX_PAGES)) begin
               bank_in  = !bank_ff;
               state_in = ST_R_DONE;
            end else begin
               cnt_in = cnt_ff + PAGE_CNT_W'(1);
            end
         end
         ST_R_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_page_in   = '0;
               rsp_offset_in = '0;
               rsp_freed_in  = k_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         k_ff          <= '0;
         piu_ff        <= PAGE_CNT_W'(1);
         bank_ff       <= 1'b0;
         page_bytes_ff <= PAGE_BYTES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         k_ff          <= k_in;
         piu_ff        <= piu_in;
         bank_ff       <= bank_in;
         page_bytes_ff <= page_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      size_ff       <= size_in;
      align_ff      <= align_in;
      fence_ff      <= fence_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                        rsp_freed_ff, rsp_offset_ff, rsp_page_ff};

   // The list never shrinks below one page nor grows past the pool.
   a_piu_range: assert property (@(posedge clock) disable iff (reset)
      (piu_ff >= PAGE_CNT_W'(1)) && (piu_ff <= PAGE_CNT_W'(MAX_PAGES)))
      else $error("pages in use out of range");

   // The reclaim walk never counts past the end of the list.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_ISSUE || state_ff == ST_R_SLOT || state_ff == ST_R_TEST ||
       state_ff == ST_COPY || state_ff == ST_R_DONE) |-> (k_ff <= piu_ff))
      else $error("reclaim walk passed the list end");

   // A new result only comes from one of the two completing states.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == ST_A_CALC || $past(state_ff) == ST_R_DONE))
      else $error("result loaded outside a completing state");

   // A fresh page grows the list by exactly one.
   a_new_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_CALC && out_free && !fits && !too_large && !pool_full) |=>
         (piu_ff == $past(piu_ff) + PAGE_CNT_W'(1)))
      else $error("list length not bumped on a new page");

endmodule
